// ----- rtl/core/i2c_eeprom_byte_access_master_top_defines.svh -----
// ----------------------------------------------------------------------------
// i2c eeprom byte access master: assertion macros
// Shared concurrent assertion helpers, clocked on clk, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef I2C_EEPROM_BYTE_ACCESS_MASTER_TOP_DEFINES_SVH
`define I2C_EEPROM_BYTE_ACCESS_MASTER_TOP_DEFINES_SVH

// condition must hold at every clock edge out of reset
`define IEBAM_ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// consequent must hold in the cycle after the antecedent
`define IEBAM_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/core/iebam_pkg.sv -----
// ----------------------------------------------------------------------------
// iebam_pkg
// Types and constants of the i2c eeprom byte access master.
// ----------------------------------------------------------------------------
package iebam_pkg;

    // request codes
    localparam logic [1:0] OP_NONE  = 2'd0;
    localparam logic [1:0] OP_READ  = 2'd1;
    localparam logic [1:0] OP_WRITE = 2'd2;

    // configuration register indexes
    localparam int unsigned CFG_INDEX_W = 8;
    localparam logic [CFG_INDEX_W-1:0] CFG_ACK_WAIT_LIMIT    = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_WRITE_CYCLE_TICKS = 8'd1;

    // configuration reset values
    localparam logic [7:0]  ACK_WAIT_LIMIT_RST    = 8'd255;
    localparam logic [15:0] WRITE_CYCLE_TICKS_RST = 16'd1000;

    // device byte
    localparam logic [7:0] DEVICE_BASE = 8'hA0;
    localparam logic [2:0] PAGE_MASK   = 3'h7;
    localparam logic [7:0] READ_FLAG   = 8'h01;

    // ticks between read stop and read data
    localparam logic [15:0] READ_PAUSE_TICKS = 16'd2;

    // bits per byte on the bus
    localparam logic [3:0] BYTE_BITS = 4'd8;

    // stream widths
    localparam int unsigned S_TDATA_W = 24;
    localparam int unsigned M_TDATA_W = 16;

    // bus sequencer phases
    typedef enum logic [4:0] {
        PH_IDLE,
        PH_ST1,
        PH_ST2,
        PH_ST3,
        PH_ST0,
        PH_WB_LO,
        PH_WB_DAT,
        PH_WB_HI,
        PH_WB_ENDLO,
        PH_WB_REL,
        PH_ACK_HI,
        PH_ACK_WAIT,
        PH_RD_LO0,
        PH_RD_LO,
        PH_RD_HI,
        PH_RD_END,
        PH_SP0,
        PH_SP1,
        PH_SP2,
        PH_PAUSE
    } phase_t;

    // device byte from the held address, page bits in bits 3:1
    function automatic logic [7:0] device_byte(input logic [10:0] addr);
        logic [2:0] page;
        page = addr[10:8] & PAGE_MASK;
        return DEVICE_BASE | {4'b0000, page, 1'b0};
    endfunction

endpackage

// ----- rtl/core/i2c_eeprom_byte_access_master_top.sv -----
// ----------------------------------------------------------------------------
// i2c eeprom byte access master
// I2C master doing single-byte random reads and byte writes to an eeprom
// with an 11-bit address, one bus tick per stream transaction.
// ----------------------------------------------------------------------------
// Usage:
//   s_* channel: one transaction per bus tick from the prescaler. s_tuser holds
//   the request code, taken only while idle; s_tdata carries the address, the
//   write byte and the sampled SDA level of that tick.
//   m_* channel: exactly one transaction per accepted tick with the SCL and SDA
//   drive levels, busy, and the read byte together with its done pulse.
//   cfg_* channel: register writes, always ready; write only while idle.
// Output: result of a tick appears in the cycle after its acceptance, from
//   the result register.
// Throughput: one tick per cycle unless stalled; the sequencer takes one phase
//   step per tick and the result register passes a new result every cycle.
// Reset: sequencer idle, SCL and SDA released high, ack limit 255,
//   write cycle 1000 ticks, no result pending.
// Stall: while a result waits and m_tready is low, s_tready drops and the
//   sequencer holds; it resumes the cycle the result is taken.
// ----------------------------------------------------------------------------
`include "i2c_eeprom_byte_access_master_top_defines.svh"

module i2c_eeprom_byte_access_master_top (
    input  logic                                clk,
    input  logic                                rst_n,
    // tick input
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // [10:0] mem_address, [18:11] write_byte, [19] sda_sample, [23:20] zero
    input  logic [iebam_pkg::S_TDATA_W-1:0]     s_tdata,
    // [1:0] operation
    input  logic [1:0]                          s_tuser,
    // tick result
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // [0] scl_level, [1] sda_level, [2] busy_res, [3] read_done,
    // [11:4] read_byte, [15:12] zero
    output logic [iebam_pkg::M_TDATA_W-1:0]     m_tdata,
    // configuration writes
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [iebam_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [15:0]                         cfg_data
);
    import iebam_pkg::*;

    // configuration registers
    logic [7:0]  ack_wait_limit_reg;
    logic [15:0] write_cycle_ticks_reg;

    // sequencer state
    phase_t      phase_reg, phase_next;
    logic [3:0]  bit_count_reg, bit_count_next;
    logic [7:0]  shift_reg_reg, shift_reg_next;
    logic [2:0]  byte_step_reg, byte_step_next;
    logic [15:0] wait_count_reg, wait_count_next;
    logic [10:0] held_address_reg, held_address_next;
    logic [7:0]  held_data_reg, held_data_next;
    logic        is_read_reg, is_read_next;
    logic        scl_reg, scl_next;
    logic        sda_reg, sda_next;

    // result register
    logic                 out_valid_reg;
    logic [M_TDATA_W-1:0] out_data_reg;
    logic [M_TDATA_W-1:0] out_data_next;

    // per-tick outputs
    logic       busy;
    logic       done;
    logic [7:0] rbyte;

    // input fields
    logic [1:0]  in_op;
    logic [10:0] in_addr;
    logic [7:0]  in_wbyte;
    logic        in_sda;
    logic        in_accept;

    assign in_op    = s_tuser;
    assign in_addr  = s_tdata[10:0];
    assign in_wbyte = s_tdata[18:11];
    assign in_sda   = s_tdata[19];

    // handshakes
    assign s_tready  = !out_valid_reg || m_tready;
    assign in_accept = s_tvalid && s_tready;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = out_data_reg;
    assign cfg_ready = 1'b1;

    // configuration write transaction
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ack_wait_limit_reg    <= ACK_WAIT_LIMIT_RST;
            write_cycle_ticks_reg <= WRITE_CYCLE_TICKS_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_ACK_WAIT_LIMIT:    ack_wait_limit_reg    <= cfg_data[7:0];
                CFG_WRITE_CYCLE_TICKS: write_cycle_ticks_reg <= cfg_data;
                default:               ;
            endcase
        end
    end

    // next state of the bus sequencer for one tick
    always_comb
    begin
        logic [2:0]  step_inc;
        logic [3:0]  count_inc;
        logic [15:0] count_dec;
        logic [15:0] stop_wait;

        phase_next        = phase_reg;
        bit_count_next    = bit_count_reg;
        shift_reg_next    = shift_reg_reg;
        byte_step_next    = byte_step_reg;
        wait_count_next   = wait_count_reg;
        held_address_next = held_address_reg;
        held_data_next    = held_data_reg;
        is_read_next      = is_read_reg;
        scl_next          = scl_reg;
        sda_next          = sda_reg;

        step_inc  = byte_step_reg + 3'd1;
        count_inc = bit_count_reg + 4'd1;
        count_dec = (wait_count_reg != 16'd0) ? wait_count_reg - 16'd1 : wait_count_reg;
        stop_wait = is_read_reg ? READ_PAUSE_TICKS : write_cycle_ticks_reg;

        unique case (phase_reg)
            PH_IDLE:
            begin
                if (in_op == OP_READ || in_op == OP_WRITE)
                begin
                    held_address_next = in_addr;
                    held_data_next    = in_wbyte;
                    is_read_next      = (in_op == OP_READ);
                    byte_step_next    = 3'd0;
                    sda_next          = 1'b1;
                    phase_next        = PH_ST1;
                end
            end
            PH_ST0:
            begin
                sda_next   = 1'b1;
                phase_next = PH_ST1;
            end
            PH_ST1:
            begin
                scl_next   = 1'b1;
                phase_next = PH_ST2;
            end
            PH_ST2:
            begin
                sda_next   = 1'b0;
                phase_next = PH_ST3;
            end
            PH_ST3:
            begin
                scl_next       = 1'b0;
                shift_reg_next = (byte_step_reg == 3'd0) ? device_byte(held_address_reg)
                                 : (device_byte(held_address_reg) | READ_FLAG);
                bit_count_next = 4'd0;
                phase_next     = PH_WB_LO;
            end
            PH_WB_LO:
            begin
                scl_next   = 1'b0;
                phase_next = PH_WB_DAT;
            end
            PH_WB_DAT:
            begin
                sda_next       = shift_reg_reg[7];
                shift_reg_next = {shift_reg_reg[6:0], 1'b0};
                phase_next     = PH_WB_HI;
            end
            PH_WB_HI:
            begin
                scl_next       = 1'b1;
                bit_count_next = count_inc;
                phase_next     = (count_inc >= BYTE_BITS) ? PH_WB_ENDLO : PH_WB_LO;
            end
            PH_WB_ENDLO:
            begin
                scl_next   = 1'b0;
                phase_next = PH_WB_REL;
            end
            PH_WB_REL:
            begin
                sda_next   = 1'b1;
                phase_next = PH_ACK_HI;
            end
            PH_ACK_HI:
            begin
                scl_next        = 1'b1;
                wait_count_next = 16'd0;
                phase_next      = PH_ACK_WAIT;
            end
            PH_ACK_WAIT:
            begin
                // hold scl high until ack or limit, then pick the next byte
                if (in_sda && (wait_count_reg < {8'd0, ack_wait_limit_reg}))
                begin
                    wait_count_next = wait_count_reg + 16'd1;
                end
                else
                begin
                    scl_next       = 1'b0;
                    byte_step_next = step_inc;
                    if (step_inc == 3'd1)
                    begin
                        shift_reg_next = held_address_reg[7:0];
                        bit_count_next = 4'd0;
                        phase_next     = PH_WB_LO;
                    end
                    else if (is_read_reg)
                    begin
                        phase_next = (step_inc == 3'd2) ? PH_ST0 : PH_RD_LO0;
                    end
                    else if (step_inc == 3'd2)
                    begin
                        shift_reg_next = held_data_reg;
                        bit_count_next = 4'd0;
                        phase_next     = PH_WB_LO;
                    end
                    else
                    begin
                        phase_next = PH_SP0;
                    end
                end
            end
            PH_RD_LO0:
            begin
                scl_next       = 1'b0;
                sda_next       = 1'b1;
                shift_reg_next = 8'd0;
                bit_count_next = 4'd0;
                phase_next     = PH_RD_LO;
            end
            PH_RD_LO:
            begin
                scl_next   = 1'b0;
                phase_next = PH_RD_HI;
            end
            PH_RD_HI:
            begin
                scl_next       = 1'b1;
                shift_reg_next = {shift_reg_reg[6:0], in_sda};
                bit_count_next = count_inc;
                phase_next     = (count_inc >= BYTE_BITS) ? PH_RD_END : PH_RD_LO;
            end
            PH_RD_END:
            begin
                scl_next   = 1'b0;
                phase_next = PH_SP0;
            end
            PH_SP0:
            begin
                sda_next   = 1'b0;
                phase_next = PH_SP1;
            end
            PH_SP1:
            begin
                scl_next   = 1'b1;
                phase_next = PH_SP2;
            end
            PH_SP2:
            begin
                sda_next        = 1'b1;
                wait_count_next = stop_wait;
                phase_next      = (stop_wait == 16'd0) ? PH_IDLE : PH_PAUSE;
            end
            PH_PAUSE:
            begin
                wait_count_next = count_dec;
                if (count_dec == 16'd0)
                begin
                    phase_next = PH_IDLE;
                end
            end
            default:
            begin
                phase_next = PH_IDLE;
            end
        endcase
    end

    // result fields for one tick
    always_comb
    begin
        busy  = 1'b1;
        done  = 1'b0;
        rbyte = 8'd0;
        unique case (phase_reg) inside
            PH_IDLE:
            begin
                busy = (in_op == OP_READ || in_op == OP_WRITE);
            end
            PH_PAUSE:
            begin
                if (wait_count_next == 16'd0 && is_read_reg)
                begin
                    done  = 1'b1;
                    rbyte = shift_reg_reg;
                end
            end
            PH_ST0, PH_ST1, PH_ST2, PH_ST3, PH_WB_LO, PH_WB_DAT, PH_WB_HI,
            PH_WB_ENDLO, PH_WB_REL, PH_ACK_HI, PH_ACK_WAIT, PH_RD_LO0,
            PH_RD_LO, PH_RD_HI, PH_RD_END, PH_SP0, PH_SP1, PH_SP2:
            begin
                busy = 1'b1;
            end
            default:
            begin
                busy = 1'b0;
            end
        endcase
        out_data_next = {4'd0, rbyte, done, busy, sda_next, scl_next};
    end

    // sequencer registers advance on each accepted tick
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= PH_IDLE;
            bit_count_reg    <= 4'd0;
            shift_reg_reg    <= 8'd0;
            byte_step_reg    <= 3'd0;
            wait_count_reg   <= 16'd0;
            held_address_reg <= 11'd0;
            held_data_reg    <= 8'd0;
            is_read_reg      <= 1'b0;
            scl_reg          <= 1'b1;
            sda_reg          <= 1'b1;
        end
        else if (in_accept)
        begin
            phase_reg        <= phase_next;
            bit_count_reg    <= bit_count_next;
            shift_reg_reg    <= shift_reg_next;
            byte_step_reg    <= byte_step_next;
            wait_count_reg   <= wait_count_next;
            held_address_reg <= held_address_next;
            held_data_reg    <= held_data_next;
            is_read_reg      <= is_read_next;
            scl_reg          <= scl_next;
            sda_reg          <= sda_next;
        end
    end

    // result register, refilled on accept, emptied when taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (in_accept)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            out_data_reg <= out_data_next;
        end
    end

    // checks on the sequencer
    `IEBAM_ASSERT_ALWAYS(a_bit_count_range, bit_count_reg <= BYTE_BITS,
        "bit counter ran past one byte")
    `IEBAM_ASSERT_ALWAYS(a_byte_step_range, byte_step_reg <= 3'd3,
        "byte step past the last byte of an access")
    `IEBAM_ASSERT_ALWAYS(a_pause_nonzero, (phase_reg != PH_PAUSE) || (wait_count_reg != 16'd0),
        "pause phase with an empty tick counter")
    `IEBAM_ASSERT_ALWAYS(a_done_busy, !(out_valid_reg && out_data_reg[3]) || out_data_reg[2],
        "read done reported on a tick that is not busy")
    `IEBAM_ASSERT_NEXT(a_stall_holds_state, out_valid_reg && !m_tready,
        $stable(phase_reg) && $stable(wait_count_reg),
        "sequencer advanced while its result was stalled")

endmodule

// ----- tb/testbench.sv -----
// ----------------------------------------------------------------------------
// i2c eeprom byte access master testbench
// Drives bus ticks into the master while acting as the eeprom side on SDA,
// predicts the SCL/SDA levels, busy, and read data of every tick with a
// cycle-level model, and compares each result transaction field by field.
// Directed accesses cover address and data extremes, register extremes,
// missing acknowledges and ignored requests; random rounds follow.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;

    import iebam_pkg::*;

    // levels and data the master shows for one tick
    typedef struct {
        logic       scl;
        logic       sda;
        logic       busy;
        logic       read_done;
        logic [7:0] read_byte;
    } tick_levels_t;

    // cycle-level model of the bus sequencer plus the queue of predicted ticks
    class bus_tick_model;
        logic [7:0]     ack_limit;
        logic [15:0]    prog_ticks;
        phase_t         phase;
        logic [3:0]     bit_cnt;
        logic [7:0]     shift_q;
        logic [2:0]     byte_idx;
        logic [15:0]    wait_cnt;
        logic [10:0]    addr_q;
        logic [7:0]     data_q;
        logic           reading;
        logic           scl_q;
        logic           sda_q;
        tick_levels_t   pending_levels[$];
        int             errors;
        int             ticks;
        int             read_reqs;
        int             write_reqs;
        int             bytes_returned;

        function new();
            ack_limit      = ACK_WAIT_LIMIT_RST;
            prog_ticks     = WRITE_CYCLE_TICKS_RST;
            phase          = PH_IDLE;
            bit_cnt        = '0;
            shift_q        = '0;
            byte_idx       = '0;
            wait_cnt       = '0;
            addr_q         = '0;
            data_q         = '0;
            reading        = 1'b0;
            scl_q          = 1'b1;
            sda_q          = 1'b1;
            errors         = 0;
            ticks          = 0;
            read_reqs      = 0;
            write_reqs     = 0;
            bytes_returned = 0;
        endfunction

        // register write; unused indexes leave everything as is
        function void set_register(logic [7:0] index, logic [15:0] value);
            if (index == CFG_ACK_WAIT_LIMIT)
                ack_limit = value[7:0];
            else if (index == CFG_WRITE_CYCLE_TICKS)
                prog_ticks = value;
        endfunction

        // control byte: fixed base, page bits in 3:1, read flag in bit 0
        function logic [7:0] slave_address(logic rd_flag);
            return DEVICE_BASE | {4'b0000, addr_q[10:8], rd_flag};
        endfunction

        function void load_shift(logic [7:0] b);
            shift_q = b;
            bit_cnt = '0;
            phase   = PH_WB_LO;
        endfunction

        // sequence step after an acknowledge slot
        function void next_byte();
            byte_idx = byte_idx + 3'd1;
            if (reading) begin
                if (byte_idx == 3'd1)
                    load_shift(addr_q[7:0]);
                else if (byte_idx == 3'd2)
                    phase = PH_ST0;
                else
                    phase = PH_RD_LO0;
            end
            else begin
                if (byte_idx == 3'd1)
                    load_shift(addr_q[7:0]);
                else if (byte_idx == 3'd2)
                    load_shift(data_q);
                else
                    phase = PH_SP0;
            end
        endfunction

        // advance one tick and queue the levels it produces
        function void take_tick(logic [1:0] op, logic [10:0] addr, logic [7:0] wdata,
                                logic sda_in);
            tick_levels_t lv;
            lv.busy      = 1'b1;
            lv.read_done = 1'b0;
            lv.read_byte = '0;
            case (phase)
                PH_IDLE:
                begin
                    if (op == OP_READ || op == OP_WRITE) begin
                        addr_q   = addr;
                        data_q   = wdata;
                        reading  = (op == OP_READ);
                        byte_idx = '0;
                        sda_q    = 1'b1;
                        phase    = PH_ST1;
                        if (reading)
                            read_reqs++;
                        else
                            write_reqs++;
                    end
                    else begin
                        lv.busy = 1'b0;
                    end
                end
                PH_ST0:
                begin
                    sda_q = 1'b1;
                    phase = PH_ST1;
                end
                PH_ST1:
                begin
                    scl_q = 1'b1;
                    phase = PH_ST2;
                end
                PH_ST2:
                begin
                    sda_q = 1'b0;
                    phase = PH_ST3;
                end
                PH_ST3:
                begin
                    scl_q = 1'b0;
                    load_shift(slave_address(byte_idx != 3'd0));
                end
                PH_WB_LO:
                begin
                    scl_q = 1'b0;
                    phase = PH_WB_DAT;
                end
                PH_WB_DAT:
                begin
                    sda_q   = shift_q[7];
                    shift_q = {shift_q[6:0], 1'b0};
                    phase   = PH_WB_HI;
                end
                PH_WB_HI:
                begin
                    scl_q   = 1'b1;
                    bit_cnt = bit_cnt + 4'd1;
                    phase   = (bit_cnt >= BYTE_BITS) ? PH_WB_ENDLO : PH_WB_LO;
                end
                PH_WB_ENDLO:
                begin
                    scl_q = 1'b0;
                    phase = PH_WB_REL;
                end
                PH_WB_REL:
                begin
                    sda_q = 1'b1;
                    phase = PH_ACK_HI;
                end
                PH_ACK_HI:
                begin
                    scl_q    = 1'b1;
                    wait_cnt = '0;
                    phase    = PH_ACK_WAIT;
                end
                // no ack yet and limit not reached: keep waiting
                PH_ACK_WAIT:
                begin
                    if (sda_in && wait_cnt < {8'h00, ack_limit}) begin
                        wait_cnt = wait_cnt + 16'd1;
                    end
                    else begin
                        scl_q = 1'b0;
                        next_byte();
                    end
                end
                PH_RD_LO0:
                begin
                    scl_q   = 1'b0;
                    sda_q   = 1'b1;
                    shift_q = '0;
                    bit_cnt = '0;
                    phase   = PH_RD_LO;
                end
                PH_RD_LO:
                begin
                    scl_q = 1'b0;
                    phase = PH_RD_HI;
                end
                PH_RD_HI:
                begin
                    scl_q   = 1'b1;
                    shift_q = {shift_q[6:0], sda_in};
                    bit_cnt = bit_cnt + 4'd1;
                    phase   = (bit_cnt >= BYTE_BITS) ? PH_RD_END : PH_RD_LO;
                end
                PH_RD_END:
                begin
                    scl_q = 1'b0;
                    phase = PH_SP0;
                end
                PH_SP0:
                begin
                    sda_q = 1'b0;
                    phase = PH_SP1;
                end
                PH_SP1:
                begin
                    scl_q = 1'b1;
                    phase = PH_SP2;
                end
                PH_SP2:
                begin
                    sda_q    = 1'b1;
                    wait_cnt = reading ? READ_PAUSE_TICKS : prog_ticks;
                    phase    = (wait_cnt == 16'd0) ? PH_IDLE : PH_PAUSE;
                end
                PH_PAUSE:
                begin
                    if (wait_cnt > 16'd0)
                        wait_cnt = wait_cnt - 16'd1;
                    if (wait_cnt == 16'd0) begin
                        if (reading) begin
                            lv.read_done = 1'b1;
                            lv.read_byte = shift_q;
                        end
                        phase = PH_IDLE;
                    end
                end
                default:
                begin
                    phase   = PH_IDLE;
                    lv.busy = 1'b0;
                end
            endcase
            lv.scl = scl_q;
            lv.sda = sda_q;
            pending_levels.push_back(lv);
            ticks++;
        endfunction

        function void check_field(string name, logic [7:0] want, logic [7:0] got);
            if (got !== want) begin
                $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
                errors++;
            end
        endfunction

        // compare one result transaction against the oldest predicted tick
        function void compare_tick(logic [15:0] tdata);
            tick_levels_t want;
            if (pending_levels.size() == 0) begin
                $display("%0t: result with no tick pending, expected none actual %0h",
                         $time, tdata);
                errors++;
                return;
            end
            want = pending_levels.pop_front();
            check_field("scl_level", {7'd0, want.scl}, {7'd0, tdata[0]});
            check_field("sda_level", {7'd0, want.sda}, {7'd0, tdata[1]});
            check_field("busy_res", {7'd0, want.busy}, {7'd0, tdata[2]});
            check_field("read_done", {7'd0, want.read_done}, {7'd0, tdata[3]});
            check_field("read_byte", want.read_byte, tdata[11:4]);
            if (want.read_done)
                bytes_returned++;
        endfunction
    endclass

    localparam int          CLK_HALF    = 10;
    localparam longint      CYCLE_LIMIT = 2_000_000;
    localparam logic [1:0]  OP_UNUSED   = 2'd3;

    logic                       clk       = 1'b0;
    logic                       rst_n     = 1'b0;
    logic                       s_tvalid  = 1'b0;
    logic [S_TDATA_W-1:0]       s_tdata   = '0;
    logic [1:0]                 s_tuser   = OP_NONE;
    logic                       m_tready  = 1'b0;
    logic                       cfg_valid = 1'b0;
    logic [CFG_INDEX_W-1:0]     cfg_index = '0;
    logic [15:0]                cfg_data  = '0;
    logic                       s_tready;
    logic                       m_tvalid;
    logic [M_TDATA_W-1:0]       m_tdata;
    logic                       cfg_ready;

    bus_tick_model  model;
    int             ack_odds   = 100;
    bit             gaps_on    = 1'b1;
    int             burst_left = 8;
    longint         cycles     = 0;
    logic [15:0]    stall_pattern = 16'hFFFF;
    int             stall_mode = 0;

    i2c_eeprom_byte_access_master_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // clock
    always #CLK_HALF clk = ~clk;

    // run limit
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("i2c_eeprom_byte_access_master_top: mismatch");
            $finish;
        end
    end

    // result side: check each transaction, stall in changing modes
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            model.compare_tick(m_tdata);
        if (cycles % 97 == 0) begin
            stall_mode    = $urandom_range(0, 3);
            stall_pattern = 16'($urandom);
        end
        case (stall_mode)
            0:       m_tready <= 1'b1;
            1:       m_tready <= ($urandom_range(0, 99) < 70);
            2:       m_tready <= stall_pattern[4'(cycles % 16)];
            default: m_tready <= ($urandom_range(0, 99) < 25);
        endcase
    end

    // eeprom side of SDA: acknowledge with the set odds, random data otherwise
    function automatic logic pick_sda();
        if (model.phase == PH_ACK_HI || model.phase == PH_ACK_WAIT)
            return ($urandom_range(0, 99) >= ack_odds);
        return 1'($urandom_range(0, 1));
    endfunction

    // one tick transaction, then maybe a gap at the end of a burst
    task automatic send_tick(input logic [1:0] op, input logic [10:0] addr,
                             input logic [7:0] wdata, input logic sda_in);
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {4'b0000, sda_in, wdata, addr};
        do @(posedge clk); while (!s_tready);
        model.take_tick(op, addr, wdata, sda_in);
        if (gaps_on) begin
            burst_left--;
            if (burst_left <= 0) begin
                s_tvalid <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge clk);
                burst_left = $urandom_range(1, 40);
            end
        end
    endtask

    // tick during an access; any request code here must be ignored
    task automatic busy_tick();
        send_tick(2'($urandom_range(0, 3)), 11'($urandom_range(0, 2047)),
                  8'($urandom_range(0, 255)), pick_sda());
    endtask

    task automatic finish_access();
        while (model.phase != PH_IDLE)
            busy_tick();
    endtask

    task automatic run_access(input logic [1:0] op, input logic [10:0] addr,
                              input logic [7:0] wdata);
        finish_access();
        send_tick(op, addr, wdata, pick_sda());
        finish_access();
    endtask

    // random tick: mostly requests when idle, noise while busy
    task automatic random_tick();
        int pick;
        logic [1:0] op;
        if (model.phase != PH_IDLE) begin
            busy_tick();
        end
        else begin
            pick = $urandom_range(0, 99);
            if (pick < 45)
                op = OP_READ;
            else if (pick < 90)
                op = OP_WRITE;
            else if (pick < 95)
                op = OP_NONE;
            else
                op = OP_UNUSED;
            send_tick(op, 11'($urandom_range(0, 2047)), 8'($urandom_range(0, 255)),
                      pick_sda());
        end
    endtask

    // stop sending and wait for every predicted tick to come out
    task automatic drain();
        s_tvalid <= 1'b0;
        while (model.pending_levels.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic cfg_write(input logic [7:0] index, input logic [15:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        model.set_register(index, value);
    endtask

    // both registers plus one write to an unused index, only while idle
    task automatic program_registers(input logic [7:0] ack, input logic [15:0] hold);
        finish_access();
        drain();
        cfg_write(CFG_ACK_WAIT_LIMIT, {8'h00, ack});
        cfg_write(CFG_WRITE_CYCLE_TICKS, hold);
        cfg_write(8'($urandom_range(2, 255)), 16'($urandom));
        cfg_valid <= 1'b0;
    endtask

    initial
    begin
        logic [7:0]  ack;
        logic [15:0] hold;
        model = new();
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: idle ticks, the unused code and a read at reset settings
        send_tick(OP_NONE, 11'h000, 8'h00, 1'b0);
        send_tick(OP_UNUSED, 11'h7FF, 8'hFF, 1'b1);
        run_access(OP_READ, 11'h000, 8'h00);

        // zero ack limit and zero write cycle, slave never acknowledges
        program_registers(8'd0, 16'd0);
        ack_odds = 0;
        run_access(OP_WRITE, 11'h555, 8'h00);
        run_access(OP_READ, 11'h2AA, 8'hA5);

        // longest ack limit, acks arriving early and late
        program_registers(8'd255, 16'd60);
        ack_odds = 100;
        run_access(OP_READ, 11'h7FF, 8'h00);
        ack_odds = 5;
        run_access(OP_WRITE, 11'h7FF, 8'hFF);

        program_registers(8'd3, 16'd1);
        ack_odds = 50;
        run_access(OP_READ, 11'h123, 8'h3C);
        run_access(OP_WRITE, 11'h0FF, 8'h80);

        // random rounds with fresh settings each
        for (int round = 0; round < 5; round++) begin
            case ($urandom_range(0, 5))
                0:       ack = 8'd0;
                1:       ack = 8'd1;
                2:       ack = 8'd255;
                default: ack = 8'($urandom_range(2, 15));
            endcase
            case ($urandom_range(0, 3))
                0:       hold = 16'd0;
                1:       hold = 16'd1;
                default: hold = 16'($urandom_range(2, 40));
            endcase
            case ($urandom_range(0, 3))
                0:       ack_odds = 100;
                1:       ack_odds = 60;
                2:       ack_odds = 25;
                default: ack_odds = 0;
            endcase
            gaps_on = (round % 3 != 2);
            program_registers(ack, hold);
            repeat (100) random_tick();
        end

        finish_access();
        drain();
        $display("covered %0d ticks: %0d reads and %0d writes started, %0d read bytes returned",
                 model.ticks, model.read_reqs, model.write_reqs, model.bytes_returned);
        $display("ack limit ranged from zero to full, write cycle from zero to tens of ticks");
        if (model.errors == 0 && model.pending_levels.size() == 0)
            $display("i2c_eeprom_byte_access_master_top: match");
        else
            $display("i2c_eeprom_byte_access_master_top: mismatch");
        $finish;
    end

endmodule

// ----- filelist.f -----
+incdir+rtl/core
rtl/core/iebam_pkg.sv
rtl/core/i2c_eeprom_byte_access_master_top.sv
tb/testbench.sv
